// File: src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg: shared types, register indexes and microprogram for the LCD SPI
// command sequencer.
// ----------------------------------------------------------------------------
package lsc_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INIT     = 2'd0,
    REQ_ROTATE   = 2'd1,
    REQ_FRAME    = 2'd2,
    REQ_SHUTDOWN = 2'd3
  } req_type_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLOR_DEPTH_12  = 2'd0;
  localparam logic [1:0] CFG_COLUMN_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_ROW_OFFSET_NORM = 2'd2;
  localparam logic [1:0] CFG_ROW_OFFSET_ROT  = 2'd3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Reset values of the offset configuration registers
  localparam logic [7:0] ColumnOffsetRst  = 8'd40;
  localparam logic [7:0] RowOffsetNormRst = 8'd53;
  localparam logic [7:0] RowOffsetRotRst  = 8'd52;

  // Fixed bytes
  localparam logic [7:0] PixFmt12   = 8'h03;
  localparam logic [7:0] PixFmt16   = 8'h05;
  localparam logic [7:0] MadctlRot  = 8'hb0;
  localparam logic [7:0] MadctlNorm = 8'h70;

  typedef struct packed {
    logic [1:0] req_type;
    logic       rotate;
    logic [8:0] frame_width;
    logic [8:0] frame_height;
    logic [9:0] row_stride;
  } req_t;

  typedef struct packed {
    logic [7:0]  spi_byte;
    logic        is_data;
    logic        pause_after;
    logic [18:0] pixel_byte_count;
    logic        last;
  } rsp_t;

  // Byte source of a microstep
  typedef enum logic [3:0] {
    SRC_LIT,
    SRC_COLOR,
    SRC_ROT,
    SRC_X_HI,
    SRC_X_LO,
    SRC_XE_HI,
    SRC_XE_LO,
    SRC_Y_HI,
    SRC_Y_LO,
    SRC_YE_HI,
    SRC_YE_LO
  } src_e;

  // Branch at the end of a microstep
  typedef enum logic {
    BR_NEXT,
    BR_DONE
  } branch_e;

  // One control word
  typedef struct packed {
    src_e       src;
    logic [7:0] lit;
    logic       is_data;
    logic       pause;
    logic       cnt_en;
    branch_e    branch;
  } ucode_t;

  localparam int unsigned PcW = 7;

  // Routine entry points
  localparam logic [PcW-1:0] EntryInit     = 7'd0;
  localparam logic [PcW-1:0] EntryRotate   = 7'd60;
  localparam logic [PcW-1:0] EntryFrame    = 7'd62;
  localparam logic [PcW-1:0] EntryShutdown = 7'd75;

  function automatic logic [PcW-1:0] entry_addr(logic [1:0] req);
    logic [PcW-1:0] a;
    case (req)
      REQ_INIT:     a = EntryInit;
      REQ_ROTATE:   a = EntryRotate;
      REQ_FRAME:    a = EntryFrame;
      REQ_SHUTDOWN: a = EntryShutdown;
      default:      a = EntryInit;
    endcase
    return a;
  endfunction

  function automatic ucode_t uc_cmd(logic [7:0] lit, logic pause, branch_e br);
    ucode_t u;
    u.src     = SRC_LIT;
    u.lit     = lit;
    u.is_data = 1'b0;
    u.pause   = pause;
    u.cnt_en  = 1'b0;
    u.branch  = br;
    return u;
  endfunction

  function automatic ucode_t uc_dat(src_e src, logic [7:0] lit, branch_e br);
    ucode_t u;
    u.src     = src;
    u.lit     = lit;
    u.is_data = 1'b1;
    u.pause   = 1'b0;
    u.cnt_en  = 1'b0;
    u.branch  = br;
    return u;
  endfunction

  // Microprogram: init 0..59, rotate 60..61, frame 62..74, shutdown 75..76
  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t u;
    case (pc)
      7'd0:  u = uc_cmd(8'h36, 1'b0, BR_NEXT);
      7'd1:  u = uc_dat(SRC_LIT, 8'h70, BR_NEXT);
      7'd2:  u = uc_cmd(8'hb2, 1'b0, BR_NEXT);
      7'd3:  u = uc_dat(SRC_LIT, 8'h0c, BR_NEXT);
      7'd4:  u = uc_dat(SRC_LIT, 8'h0c, BR_NEXT);
      7'd5:  u = uc_dat(SRC_LIT, 8'h00, BR_NEXT);
      7'd6:  u = uc_dat(SRC_LIT, 8'h33, BR_NEXT);
      7'd7:  u = uc_dat(SRC_LIT, 8'h33, BR_NEXT);
      7'd8:  u = uc_cmd(8'hb7, 1'b0, BR_NEXT);
      7'd9:  u = uc_dat(SRC_LIT, 8'h35, BR_NEXT);
      7'd10: u = uc_cmd(8'hbb, 1'b0, BR_NEXT);
      7'd11: u = uc_dat(SRC_LIT, 8'h19, BR_NEXT);
      7'd12: u = uc_cmd(8'hc0, 1'b0, BR_NEXT);
      7'd13: u = uc_dat(SRC_LIT, 8'h2c, BR_NEXT);
      7'd14: u = uc_cmd(8'hc2, 1'b0, BR_NEXT);
      7'd15: u = uc_dat(SRC_LIT, 8'h01, BR_NEXT);
      7'd16: u = uc_cmd(8'hc3, 1'b0, BR_NEXT);
      7'd17: u = uc_dat(SRC_LIT, 8'h12, BR_NEXT);
      7'd18: u = uc_cmd(8'hc4, 1'b0, BR_NEXT);
      7'd19: u = uc_dat(SRC_LIT, 8'h20, BR_NEXT);
      7'd20: u = uc_cmd(8'hc5, 1'b0, BR_NEXT);
      7'd21: u = uc_dat(SRC_LIT, 8'h20, BR_NEXT);
      7'd22: u = uc_cmd(8'hc6, 1'b0, BR_NEXT);
      7'd23: u = uc_dat(SRC_LIT, 8'h0f, BR_NEXT);
      7'd24: u = uc_cmd(8'hd0, 1'b0, BR_NEXT);
      7'd25: u = uc_dat(SRC_LIT, 8'ha4, BR_NEXT);
      7'd26: u = uc_dat(SRC_LIT, 8'ha1, BR_NEXT);
      // positive gamma
      7'd27: u = uc_cmd(8'he0, 1'b0, BR_NEXT);
      7'd28: u = uc_dat(SRC_LIT, 8'hd0, BR_NEXT);
      7'd29: u = uc_dat(SRC_LIT, 8'h04, BR_NEXT);
      7'd30: u = uc_dat(SRC_LIT, 8'h0d, BR_NEXT);
      7'd31: u = uc_dat(SRC_LIT, 8'h11, BR_NEXT);
      7'd32: u = uc_dat(SRC_LIT, 8'h13, BR_NEXT);
      7'd33: u = uc_dat(SRC_LIT, 8'h2b, BR_NEXT);
      7'd34: u = uc_dat(SRC_LIT, 8'h3f, BR_NEXT);
      7'd35: u = uc_dat(SRC_LIT, 8'h54, BR_NEXT);
      7'd36: u = uc_dat(SRC_LIT, 8'h4c, BR_NEXT);
      7'd37: u = uc_dat(SRC_LIT, 8'h18, BR_NEXT);
      7'd38: u = uc_dat(SRC_LIT, 8'h0d, BR_NEXT);
      7'd39: u = uc_dat(SRC_LIT, 8'h0b, BR_NEXT);
      7'd40: u = uc_dat(SRC_LIT, 8'h1f, BR_NEXT);
      7'd41: u = uc_dat(SRC_LIT, 8'h23, BR_NEXT);
      // negative gamma
      7'd42: u = uc_cmd(8'he1, 1'b0, BR_NEXT);
      7'd43: u = uc_dat(SRC_LIT, 8'hd0, BR_NEXT);
      7'd44: u = uc_dat(SRC_LIT, 8'h04, BR_NEXT);
      7'd45: u = uc_dat(SRC_LIT, 8'h0c, BR_NEXT);
      7'd46: u = uc_dat(SRC_LIT, 8'h11, BR_NEXT);
      7'd47: u = uc_dat(SRC_LIT, 8'h13, BR_NEXT);
      7'd48: u = uc_dat(SRC_LIT, 8'h2c, BR_NEXT);
      7'd49: u = uc_dat(SRC_LIT, 8'h3f, BR_NEXT);
      7'd50: u = uc_dat(SRC_LIT, 8'h44, BR_NEXT);
      7'd51: u = uc_dat(SRC_LIT, 8'h51, BR_NEXT);
      7'd52: u = uc_dat(SRC_LIT, 8'h2f, BR_NEXT);
      7'd53: u = uc_dat(SRC_LIT, 8'h1f, BR_NEXT);
      7'd54: u = uc_dat(SRC_LIT, 8'h1f, BR_NEXT);
      7'd55: u = uc_dat(SRC_LIT, 8'h20, BR_NEXT);
      7'd56: u = uc_dat(SRC_LIT, 8'h23, BR_NEXT);
      7'd57: u = uc_cmd(8'h21, 1'b0, BR_NEXT);
      7'd58: u = uc_cmd(8'h11, 1'b1, BR_NEXT);
      7'd59: u = uc_cmd(8'h29, 1'b1, BR_DONE);
      // rotate
      7'd60: u = uc_cmd(8'h36, 1'b0, BR_NEXT);
      7'd61: u = uc_dat(SRC_ROT, 8'h00, BR_DONE);
      // frame start
      7'd62: u = uc_cmd(8'h3a, 1'b0, BR_NEXT);
      7'd63: u = uc_dat(SRC_COLOR, 8'h00, BR_NEXT);
      7'd64: u = uc_cmd(8'h2a, 1'b0, BR_NEXT);
      7'd65: u = uc_dat(SRC_X_HI, 8'h00, BR_NEXT);
      7'd66: u = uc_dat(SRC_X_LO, 8'h00, BR_NEXT);
      7'd67: u = uc_dat(SRC_XE_HI, 8'h00, BR_NEXT);
      7'd68: u = uc_dat(SRC_XE_LO, 8'h00, BR_NEXT);
      7'd69: u = uc_cmd(8'h2b, 1'b0, BR_NEXT);
      7'd70: u = uc_dat(SRC_Y_HI, 8'h00, BR_NEXT);
      7'd71: u = uc_dat(SRC_Y_LO, 8'h00, BR_NEXT);
      7'd72: u = uc_dat(SRC_YE_HI, 8'h00, BR_NEXT);
      7'd73: u = uc_dat(SRC_YE_LO, 8'h00, BR_NEXT);
      7'd74: begin
        u        = uc_cmd(8'h2c, 1'b0, BR_DONE);
        u.cnt_en = 1'b1;
      end
      // shutdown
      7'd75: u = uc_cmd(8'h28, 1'b1, BR_NEXT);
      7'd76: u = uc_cmd(8'h10, 1'b1, BR_DONE);
      default: u = uc_cmd(8'h00, 1'b0, BR_DONE);
    endcase
    return u;
  endfunction

endpackage

// File: src/lsc_datapath.sv
// ----------------------------------------------------------------------------
// lsc_datapath: config registers, request operands, window arithmetic and
// the byte select driven by the current control word.
// ----------------------------------------------------------------------------
module lsc_datapath import lsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                load_i,
  input  req_t                req_i,
  input  ucode_t              uc_i,
  output logic [7:0]          byte_o,
  output logic [18:0]         count_o
);

  logic       color_q;
  logic [7:0] col_q, rown_q, rowr_q;
  logic       rot_flag_q;

  logic       rotate_q;
  logic [8:0] width_q, height_q;
  logic [9:0] stride_q;

  logic [15:0] xend_q, yend_q;
  logic [18:0] count_q;
  logic [7:0]  y_origin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q    <= 1'b0;
      col_q      <= ColumnOffsetRst;
      rown_q     <= RowOffsetNormRst;
      rowr_q     <= RowOffsetRotRst;
      rot_flag_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLOR_DEPTH_12:  color_q <= cfg_data_i[0];
          CFG_COLUMN_OFFSET:   col_q   <= cfg_data_i;
          CFG_ROW_OFFSET_NORM: rown_q  <= cfg_data_i;
          CFG_ROW_OFFSET_ROT:  rowr_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (load_i) begin
        case (req_i.req_type)
          REQ_INIT:   rot_flag_q <= 1'b0;
          REQ_ROTATE: rot_flag_q <= req_i.rotate;
          default: ;
        endcase
      end
    end
  end

  assign y_origin = rot_flag_q ? rowr_q : rown_q;

  // Operands, then window ends and byte count registered from them in the cycle after
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rotate_q <= req_i.rotate;
      width_q  <= req_i.frame_width;
      height_q <= req_i.frame_height;
      stride_q <= req_i.row_stride;
    end
    xend_q  <= {8'd0, col_q} + {7'd0, width_q} - 16'd1;
    yend_q  <= {8'd0, y_origin} + {7'd0, height_q} - 16'd1;
    count_q <= {9'd0, stride_q} * {10'd0, height_q};
  end

  always_comb begin
    case (uc_i.src)
      SRC_LIT:   byte_o = uc_i.lit;
      SRC_COLOR: byte_o = color_q ? PixFmt12 : PixFmt16;
      SRC_ROT:   byte_o = rotate_q ? MadctlRot : MadctlNorm;
      SRC_X_HI:  byte_o = 8'd0;
      SRC_X_LO:  byte_o = col_q;
      SRC_XE_HI: byte_o = xend_q[15:8];
      SRC_XE_LO: byte_o = xend_q[7:0];
      SRC_Y_HI:  byte_o = 8'd0;
      SRC_Y_LO:  byte_o = y_origin;
      SRC_YE_HI: byte_o = yend_q[15:8];
      SRC_YE_LO: byte_o = yend_q[7:0];
      default:   byte_o = uc_i.lit;
    endcase
  end

  assign count_o = uc_i.cnt_en ? count_q : 19'd0;

endmodule

// File: src/lsc_sequencer.sv
// ----------------------------------------------------------------------------
// lsc_sequencer: step counter over the microprogram ROM, request handshake
// and output word register.
// ----------------------------------------------------------------------------
module lsc_sequencer import lsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  output logic        load_o,
  output ucode_t      uc_o,
  input  logic [7:0]  byte_i,
  input  logic [18:0] count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_rsp_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e         state_q;
  logic [PcW-1:0] pc_q;
  logic           out_valid_q;
  logic           out_valid_d;
  rsp_t           out_q;
  logic           step;

  assign in_ready_o = (state_q == ST_IDLE);
  assign load_o     = in_valid_i && in_ready_o;
  assign uc_o       = ucode_rom(pc_q);
  // advance when the output register is free or being emptied
  assign step       = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  // a new word fills the register, otherwise an accepted word empties it
  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= EntryInit;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (load_o) begin
            pc_q    <= entry_addr(req_type_i);
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step) begin
            out_q.spi_byte         <= byte_i;
            out_q.is_data          <= uc_o.is_data;
            out_q.pause_after      <= uc_o.pause;
            out_q.pixel_byte_count <= count_i;
            out_q.last             <= (uc_o.branch == BR_DONE);
            if (uc_o.branch == BR_DONE) state_q <= ST_IDLE;
            else                        pc_q    <= pc_q + 7'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: src/lcd_spi_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// lcd_spi_command_sequencer_top: turns init / rotate / frame start / shutdown
// requests into tagged LCD controller SPI byte runs.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | in        | in_valid_i/in_ready_o  | in_req_i (req_t)
//  out      | out       | out_valid_o/out_ready_i| out_rsp_o (rsp_t)
//  cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One word per cycle from the microprogram step counter while the output is
// not stalled; each request runs its routine through to its last step.
// The request accept cycle loads the entry address; the next request is taken
// once the last step of the routine has been issued to the output register.
// A stalled output freezes the step counter. Reset clears control state,
// the rotation flag and restores the window offsets; no clearing pass.
// Window ends and the pixel byte count are registered from the latched
// operands and are ready well before the frame routine reaches them.
// ----------------------------------------------------------------------------
module lcd_spi_command_sequencer_top import lsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        load;
  ucode_t      uc;
  logic [7:0]  dp_byte;
  logic [18:0] dp_count;

  lsc_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (in_req_i.req_type),
    .load_o      (load),
    .uc_o        (uc),
    .byte_i      (dp_byte),
    .count_i     (dp_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  lsc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .load_i     (load),
    .req_i      (in_req_i),
    .uc_i       (uc),
    .byte_o     (dp_byte),
    .count_o    (dp_count)
  );

endmodule
